@@ rtl/core/encoder_switch_input_scanner_assert.svh @@
// Assertion helpers shared by the scanner RTL.
`ifndef ENCODER_SWITCH_INPUT_SCANNER_ASSERT_SVH
`define ENCODER_SWITCH_INPUT_SCANNER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ESIS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ESIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/esis_pkg.sv @@
`timescale 1ns / 1ps
package esis_pkg;

  // Fixed field widths of the scan item and the result
  localparam int KNOB_W = 16;
  localparam int SIDE_W = 6;

  // Default build parameters
  localparam int DEF_ENCODER_COUNT = 16;
  localparam int DEF_SIDE_COUNT    = 6;
  localparam int DEF_HISTORY_DEPTH = 10;

  // Switch combination masks over the debounced knob switches
  localparam logic [KNOB_W-1:0] COMBO_RESET    = 16'h8001;
  localparam logic [KNOB_W-1:0] COMBO_BOOT     = 16'h9009;
  localparam logic [KNOB_W-1:0] COMBO_BOOT_ALT = 16'h8800;
  localparam logic [KNOB_W-1:0] COMBO_MIRROR   = 16'h6000;

  // Half-step rotary decoder states
  typedef enum logic [2:0] {
    ROT_START     = 3'd0,
    ROT_CCW_BEGIN = 3'd1,
    ROT_CW_BEGIN  = 3'd2,
    ROT_MIDDLE    = 3'd3,
    ROT_MID_CW    = 3'd4,
    ROT_MID_CCW   = 3'd5
  } rot_state_e;

  typedef struct packed {
    rot_state_e next;
    logic       cw;
    logic       ccw;
  } rot_step_t;

  function automatic rot_step_t mk_step(rot_state_e nxt, logic cw, logic ccw);
    rot_step_t s;
    s.next = nxt;
    s.cw   = cw;
    s.ccw  = ccw;
    return s;
  endfunction

  // Transition table, quad code is {B, A}; unused state codes act like start
  function automatic rot_step_t rot_lookup(logic [2:0] st, logic [1:0] quad);
    rot_step_t s;
    s = mk_step(ROT_START, 1'b0, 1'b0);
    case (st)
      ROT_CCW_BEGIN: begin
        case (quad)
          2'b00:   s = mk_step(ROT_MIDDLE, 1'b0, 1'b1);
          2'b10:   s = mk_step(ROT_CCW_BEGIN, 1'b0, 1'b0);
          default: s = mk_step(ROT_START, 1'b0, 1'b0);
        endcase
      end
      ROT_CW_BEGIN: begin
        case (quad)
          2'b00:   s = mk_step(ROT_MIDDLE, 1'b1, 1'b0);
          2'b01:   s = mk_step(ROT_CW_BEGIN, 1'b0, 1'b0);
          default: s = mk_step(ROT_START, 1'b0, 1'b0);
        endcase
      end
      ROT_MIDDLE: begin
        case (quad)
          2'b00:   s = mk_step(ROT_MIDDLE, 1'b0, 1'b0);
          2'b01:   s = mk_step(ROT_MID_CCW, 1'b0, 1'b0);
          2'b10:   s = mk_step(ROT_MID_CW, 1'b0, 1'b0);
          default: s = mk_step(ROT_START, 1'b0, 1'b0);
        endcase
      end
      ROT_MID_CW: begin
        case (quad)
          2'b00:   s = mk_step(ROT_MIDDLE, 1'b0, 1'b0);
          2'b01:   s = mk_step(ROT_MIDDLE, 1'b0, 1'b0);
          2'b10:   s = mk_step(ROT_MID_CW, 1'b0, 1'b0);
          default: s = mk_step(ROT_START, 1'b1, 1'b0);
        endcase
      end
      ROT_MID_CCW: begin
        case (quad)
          2'b00:   s = mk_step(ROT_MIDDLE, 1'b0, 1'b0);
          2'b01:   s = mk_step(ROT_MID_CCW, 1'b0, 1'b0);
          2'b10:   s = mk_step(ROT_MIDDLE, 1'b0, 1'b0);
          default: s = mk_step(ROT_START, 1'b0, 1'b1);
        endcase
      end
      default: begin
        case (quad)
          2'b00:   s = mk_step(ROT_MIDDLE, 1'b0, 1'b0);
          2'b01:   s = mk_step(ROT_CW_BEGIN, 1'b0, 1'b0);
          2'b10:   s = mk_step(ROT_CCW_BEGIN, 1'b0, 1'b0);
          default: s = mk_step(ROT_START, 1'b0, 1'b0);
        endcase
      end
    endcase
    return s;
  endfunction

endpackage

@@ rtl/core/encoder_switch_input_scanner.sv @@
`timescale 1ns / 1ps
// Encoder and switch input scanner.
// Input channel (in_valid_i / in_ready_o): one scan tick, carrying the A/B
// quadrature levels of the encoders, the raw encoder push switch pins (active
// low) and the raw side switch levels.
// Output channel (out_valid_o / out_ready_i): one result per tick with the
// debounced switch states, their edges, the clockwise / counter-clockwise
// half-step pulses and the reset, bootloader and mirror combination flags.
// An accepted tick sits in the input register and shows its result on the
// outputs when the result register loads.
// Throughput: one tick per cycle unless stalled; the rotary table lookup and
// the history AND form a single pass of shallow logic between both registers.
// Stall: while out_ready_i is low the result holds; the input register takes
// one more tick, after which in_ready_o drops until the result transfers.
// Reset (rst_ni low): decoders go to the start state, the switch history,
// history slot and previous debounced states clear, both registers go empty.
module encoder_switch_input_scanner #(
  parameter int ENCODER_COUNT = esis_pkg::DEF_ENCODER_COUNT,
  parameter int SIDE_COUNT    = esis_pkg::DEF_SIDE_COUNT,
  parameter int HISTORY_DEPTH = esis_pkg::DEF_HISTORY_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [esis_pkg::KNOB_W-1:0] quad_a_bits_i,
  input  logic [esis_pkg::KNOB_W-1:0] quad_b_bits_i,
  input  logic [esis_pkg::KNOB_W-1:0] knob_switch_levels_i,
  input  logic [esis_pkg::SIDE_W-1:0] side_switch_levels_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [esis_pkg::KNOB_W-1:0] knob_switch_stable_o,
  output logic [esis_pkg::KNOB_W-1:0] knob_switch_pressed_o,
  output logic [esis_pkg::KNOB_W-1:0] knob_switch_released_o,
  output logic [esis_pkg::SIDE_W-1:0] side_switch_stable_o,
  output logic [esis_pkg::SIDE_W-1:0] side_switch_rose_o,
  output logic [esis_pkg::SIDE_W-1:0] side_switch_fell_o,
  output logic [esis_pkg::KNOB_W-1:0] clockwise_steps_o,
  output logic [esis_pkg::KNOB_W-1:0] counter_clockwise_steps_o,
  output logic                        reset_combo_o,
  output logic                        bootloader_combo_o,
  output logic                        mirror_combo_o
);
  import esis_pkg::*;

`include "encoder_switch_input_scanner_assert.svh"

  localparam int SlotW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [SlotW-1:0] SlotLast = SlotW'(HISTORY_DEPTH - 1);
  localparam logic [KNOB_W-1:0] KnobMask = KNOB_W'((33'd1 << ENCODER_COUNT) - 33'd1);
  localparam logic [SIDE_W-1:0] SideMask = SIDE_W'((33'd1 << SIDE_COUNT) - 33'd1);

  // Input register
  logic              in_valid_q;
  logic [KNOB_W-1:0] qa_q, qb_q, knob_lvl_q;
  logic [SIDE_W-1:0] side_lvl_q;

  // Scanner state
  rot_state_e        rot_q [KNOB_W];
  rot_state_e        rot_d [KNOB_W];
  logic [KNOB_W-1:0] knob_hist_q [HISTORY_DEPTH];
  logic [KNOB_W-1:0] knob_hist_d [HISTORY_DEPTH];
  logic [SIDE_W-1:0] side_hist_q [HISTORY_DEPTH];
  logic [SIDE_W-1:0] side_hist_d [HISTORY_DEPTH];
  logic [SlotW-1:0]  slot_q, slot_d, slot_cur;
  logic [KNOB_W-1:0] knob_prev_q;
  logic [SIDE_W-1:0] side_prev_q;

  // Result register
  logic              out_valid_q;
  logic [KNOB_W-1:0] kst_q, kpress_q, krel_q, cw_q, ccw_q;
  logic [SIDE_W-1:0] sst_q, srose_q, sfell_q;
  logic              rst_combo_q, boot_combo_q, mir_combo_q;

  // Single-pass results
  logic [KNOB_W-1:0] cw_d, ccw_d, knob_sample, kst_d;
  logic [SIDE_W-1:0] side_sample, sst_d;
  logic              advance;

  // Move the held tick into the result register when that register frees up
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Step every encoder through the half-step table
  always_comb begin
    rot_step_t st;
    cw_d  = '0;
    ccw_d = '0;
    for (int n = 0; n < KNOB_W; n++) begin
      st = rot_lookup(rot_q[n], {qb_q[n], qa_q[n]});
      if (n < ENCODER_COUNT) begin
        rot_d[n] = st.next;
        cw_d[n]  = st.cw;
        ccw_d[n] = st.ccw;
      end else begin
        rot_d[n] = ROT_START;
      end
    end
  end

  // Write the new samples into the history and AND over all entries
  assign knob_sample = ~knob_lvl_q & KnobMask;
  assign side_sample = side_lvl_q & SideMask;
  assign slot_cur    = (32'(slot_q) >= HISTORY_DEPTH) ? '0 : slot_q;
  assign slot_d      = (slot_cur == SlotLast) ? '0 : slot_cur + 1'b1;

  always_comb begin
    kst_d = KnobMask;
    sst_d = SideMask;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (slot_cur == SlotW'(i)) begin
        knob_hist_d[i] = knob_sample;
        side_hist_d[i] = side_sample;
      end else begin
        knob_hist_d[i] = knob_hist_q[i];
        side_hist_d[i] = side_hist_q[i];
      end
      kst_d = kst_d & knob_hist_d[i];
      sst_d = sst_d & side_hist_d[i];
    end
  end

  // Hold the incoming tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      qa_q       <= quad_a_bits_i;
      qb_q       <= quad_b_bits_i;
      knob_lvl_q <= knob_switch_levels_i;
      side_lvl_q <= side_switch_levels_i;
    end
  end

  // Advance the scanner state once per consumed tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < KNOB_W; n++) rot_q[n] <= ROT_START;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        knob_hist_q[i] <= '0;
        side_hist_q[i] <= '0;
      end
      slot_q      <= '0;
      knob_prev_q <= '0;
      side_prev_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        rot_q       <= rot_d;
        knob_hist_q <= knob_hist_d;
        side_hist_q <= side_hist_d;
        slot_q      <= slot_d;
        knob_prev_q <= kst_d;
        side_prev_q <= sst_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      kst_q        <= kst_d;
      kpress_q     <= kst_d & ~knob_prev_q;
      krel_q       <= knob_prev_q & ~kst_d;
      sst_q        <= sst_d;
      srose_q      <= sst_d & ~side_prev_q;
      sfell_q      <= side_prev_q & ~sst_d;
      cw_q         <= cw_d;
      ccw_q        <= ccw_d;
      rst_combo_q  <= (kst_d & COMBO_RESET) == COMBO_RESET;
      boot_combo_q <= ((kst_d & COMBO_BOOT) == COMBO_BOOT) ||
                      ((kst_d & COMBO_BOOT_ALT) == COMBO_BOOT_ALT);
      mir_combo_q  <= (kst_d & COMBO_MIRROR) == COMBO_MIRROR;
    end
  end

  assign out_valid_o               = out_valid_q;
  assign knob_switch_stable_o      = kst_q;
  assign knob_switch_pressed_o     = kpress_q;
  assign knob_switch_released_o    = krel_q;
  assign side_switch_stable_o      = sst_q;
  assign side_switch_rose_o        = srose_q;
  assign side_switch_fell_o        = sfell_q;
  assign clockwise_steps_o         = cw_q;
  assign counter_clockwise_steps_o = ccw_q;
  assign reset_combo_o             = rst_combo_q;
  assign bootloader_combo_o        = boot_combo_q;
  assign mirror_combo_o            = mir_combo_q;

  // Checks
  `ESIS_ASSERT_NOW(a_dir_exclusive, clk_i, rst_ni, out_valid_q, (cw_q & ccw_q) == '0, "cw and ccw pulse together")
  `ESIS_ASSERT_NOW(a_press_in_stable, clk_i, rst_ni, out_valid_q, (kpress_q & ~kst_q) == '0, "pressed bit not stable")
  `ESIS_ASSERT_NOW(a_slot_range, clk_i, rst_ni, 1'b1, slot_q <= SlotLast, "history slot out of range")
  `ESIS_ASSERT_NEXT(a_prev_tracks, clk_i, rst_ni, advance, knob_prev_q == kst_q, "previous state lost")

endmodule
